// ===== hw/rtl/lcrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcrs_pkg: shared widths, codes and types of the Laplacian residual stencil
// Field widths of the stream payloads, register indexes and the structs
// that pass between the control, the arithmetic pipeline and the queue.
// ----------------------------------------------------------------------------
package lcrs_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int RES_W      = 48;
    localparam int IDX_W      = 6;
    localparam int LREG_W     = 7;
    localparam int COEF_W     = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TDATA_W    = 64;
    localparam int PAD_W      = TDATA_W - RES_W - 2 * IDX_W;
    localparam int COL_LSB    = RES_W + IDX_W;

    // result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_LENGTH   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_COUNT    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ALONG_COEFF  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ACROSS_COEFF = 2'd3;

    localparam logic [LREG_W-1:0] ROW_LENGTH_RST = 7'd31;
    localparam logic [LREG_W-1:0] ROW_COUNT_RST  = 7'd31;
    localparam logic [COEF_W-1:0] COEFF_RST      = 16'd1024;

    // request kinds
    localparam logic ACTION_PUSH  = 1'b0;
    localparam logic ACTION_DRAIN = 1'b1;

    // 2.0 in Q.12, and the half step for rounding the Q.36 cube to Q.12
    localparam logic signed [36:0] TWO_Q12   = 37'sd8192;
    localparam logic signed [47:0] CUBE_HALF = 48'sd8388608;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } tag_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] up;
        logic signed [SAMPLE_W-1:0] mid;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic signed [SAMPLE_W-1:0] down;
        tag_t                       tag;
    } operands_t;

    typedef struct packed {
        logic signed [RES_W-1:0] residual;
        tag_t                    tag;
    } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lcrs_line_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcrs_line_store: upper and middle row memories
// Two synchronous line memories with registered reads. The middle row is
// read at a column and at its right neighbour; entries not written since
// reset read as zero.
// ----------------------------------------------------------------------------
module lcrs_line_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic [AW-1:0]                        rd_addr,
    input  wire logic [AW-1:0]                        nb_addr,
    input  wire logic                                 wr_en,
    input  wire logic [AW-1:0]                        wr_addr,
    input  wire logic signed [lcrs_pkg::SAMPLE_W-1:0] wr_upper,
    input  wire logic signed [lcrs_pkg::SAMPLE_W-1:0] wr_middle,
    output logic signed [lcrs_pkg::SAMPLE_W-1:0]      up_data,
    output logic signed [lcrs_pkg::SAMPLE_W-1:0]      mid_data,
    output logic signed [lcrs_pkg::SAMPLE_W-1:0]      nb_data
);

    logic [lcrs_pkg::SAMPLE_W-1:0] upper_mem  [DEPTH];
    logic [lcrs_pkg::SAMPLE_W-1:0] middle_mem [DEPTH];

    logic [DEPTH-1:0]              written_reg;
    logic                          rd_ok_reg;
    logic                          nb_ok_reg;
    logic [lcrs_pkg::SAMPLE_W-1:0] up_q_reg;
    logic [lcrs_pkg::SAMPLE_W-1:0] mid_q_reg;
    logic [lcrs_pkg::SAMPLE_W-1:0] nb_q_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= wr_upper;
            middle_mem[wr_addr] <= wr_middle;
        end
        up_q_reg  <= upper_mem[rd_addr];
        mid_q_reg <= middle_mem[rd_addr];
        nb_q_reg  <= middle_mem[nb_addr];
    end

    // both rows are written together, so one mark per column serves both
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_ok_reg   <= 1'b0;
            nb_ok_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            rd_ok_reg <= written_reg[rd_addr];
            nb_ok_reg <= written_reg[nb_addr];
        end
    end

    assign up_data  = rd_ok_reg ? signed'(up_q_reg)  : '0;
    assign mid_data = rd_ok_reg ? signed'(mid_q_reg) : '0;
    assign nb_data  = nb_ok_reg ? signed'(nb_q_reg)  : '0;

endmodule
`default_nettype wire

// ===== hw/rtl/lcrs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcrs_datapath: residual arithmetic pipeline
// Three register stages: second differences and square, cube and linear
// sum, rounding of the cube and final difference.
// ----------------------------------------------------------------------------
module lcrs_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire lcrs_pkg::operands_t                ops,
    input  wire logic [lcrs_pkg::COEF_W-1:0]        along_coeff,
    input  wire logic [lcrs_pkg::COEF_W-1:0]        across_coeff,
    output logic                                    res_valid,
    output lcrs_pkg::result_t                       res,
    output logic [1:0]                              inflight
);

    logic signed [17:0] d_across;
    logic signed [17:0] d_along;
    logic signed [16:0] k_across;
    logic signed [16:0] k_along;
    logic signed [34:0] p_across;
    logic signed [34:0] p_along;
    logic signed [31:0] p_square;

    logic               c_valid_reg;
    logic signed [34:0] c_across_reg;
    logic signed [34:0] c_along_reg;
    logic signed [31:0] c_square_reg;
    logic signed [15:0] c_mid_reg;
    lcrs_pkg::tag_t     c_tag_reg;

    logic signed [47:0] c_cube;
    logic signed [36:0] c_lin;

    logic               d_valid_reg;
    logic signed [47:0] d_cube_reg;
    logic signed [36:0] d_lin_reg;
    lcrs_pkg::tag_t     d_tag_reg;

    logic signed [47:0] d_cube_biased;
    logic signed [23:0] d_cube_q12;
    logic signed [37:0] d_diff;

    logic               r_valid_reg;
    lcrs_pkg::result_t  r_res_reg;

    always_comb
    begin
        d_across = 18'(ops.up) + 18'(ops.down) - (18'(ops.mid) <<< 1);
        d_along  = 18'(ops.left) + 18'(ops.right) - (18'(ops.mid) <<< 1);
        k_across = signed'({1'b0, across_coeff});
        k_along  = signed'({1'b0, along_coeff});
        p_across = k_across * d_across;
        p_along  = k_along * d_along;
        p_square = ops.mid * ops.mid;
    end

    always_comb
    begin
        c_cube = c_square_reg * c_mid_reg;
        c_lin  = 37'(c_across_reg) + 37'(c_along_reg) + 37'(c_mid_reg) + lcrs_pkg::TWO_Q12;
    end

    // round to nearest, ties upward: add half and take the floor
    always_comb
    begin
        d_cube_biased = d_cube_reg + lcrs_pkg::CUBE_HALF;
        d_cube_q12    = d_cube_biased[47:24];
        d_diff        = 38'(d_lin_reg) - 38'(d_cube_q12);
    end

    always_ff @(posedge clk)
    begin
        c_across_reg <= p_across;
        c_along_reg  <= p_along;
        c_square_reg <= p_square;
        c_mid_reg    <= ops.mid;
        c_tag_reg    <= ops.tag;
        d_cube_reg   <= c_cube;
        d_lin_reg    <= c_lin;
        d_tag_reg    <= c_tag_reg;
        // the sum stays far inside the 48-bit range, so no clipping arises
        r_res_reg.residual <= 48'(d_diff);
        r_res_reg.tag      <= d_tag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= in_valid;
            d_valid_reg <= c_valid_reg;
            r_valid_reg <= d_valid_reg;
        end
    end

    assign res_valid = r_valid_reg;
    assign res       = r_res_reg;
    assign inflight  = 2'(c_valid_reg) + 2'(d_valid_reg) + 2'(r_valid_reg);

endmodule
`default_nettype wire

// ===== hw/rtl/lcrs_out_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcrs_out_queue: result queue on the master side
// A small ring of results that decouples the pipeline from the consumer.
// ----------------------------------------------------------------------------
module lcrs_out_queue (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    input  wire lcrs_pkg::result_t               push_res,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // residual[47:0], out_row[53:48], out_col[59:54], zero fill[63:60]
    output logic [lcrs_pkg::TDATA_W-1:0]         m_tdata,
    output logic                                 m_tlast,
    output logic [lcrs_pkg::QCNT_W-1:0]          count
);

    lcrs_pkg::result_t                 entry_reg [lcrs_pkg::QDEPTH];
    logic [lcrs_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [lcrs_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [lcrs_pkg::QCNT_W-1:0]       count_reg;
    logic [lcrs_pkg::QCNT_W-1:0]       count_next;
    logic                              pop;
    lcrs_pkg::result_t                 head;

    assign pop  = m_tvalid && m_tready;
    assign head = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {{lcrs_pkg::PAD_W{1'b0}}, head.tag.col, head.tag.row, head.residual};
    assign m_tlast  = head.tag.last;
    assign count    = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != lcrs_pkg::QCNT_W'(lcrs_pkg::QDEPTH)) || pop)
        else $error("result queue overflow");

endmodule
`default_nettype wire

// ===== hw/rtl/laplace_cubic_residual_stencil.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// laplace_cubic_residual_stencil: streaming five-point residual with cubic term
// Raster-order samples in, one residual per interior request out; drain
// requests flush the last row of a frame.
// ----------------------------------------------------------------------------
// The block takes no new request before the last one is written back: the
// line stores are read in the cycle a request is accepted and written back
// in the next, and no new request enters while that write-back is pending.
// A result passes the request register and the datapath stages into a
// four-entry queue, so the queue space check does not hold s_tready low
// while the consumer keeps up.
// Line-store entries never written since reset read as zero; there is no
// clearing pass after reset. Configuration must only be written while no
// request is in flight and no result is waiting.
module laplace_cubic_residual_stencil #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [lcrs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [lcrs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // sample[15:0]
    input  wire logic [lcrs_pkg::SAMPLE_W-1:0]     s_tdata,
    // action[0]
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // residual[47:0], out_row[53:48], out_col[59:54], zero fill[63:60]
    output logic [lcrs_pkg::TDATA_W-1:0]           m_tdata,
    output logic                                   m_tlast
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int LEN_W = $clog2(MAX_COLS + 1);
    localparam int ROW_W = $clog2(MAX_ROWS + 1);

    typedef struct packed {
        logic                                write;
        logic                                upd_left;
        logic                                emit;
        logic                                up_zero;
        logic                                left_zero;
        logic                                right_zero;
        logic                                down_zero;
        logic signed [lcrs_pkg::SAMPLE_W-1:0] sample;
        lcrs_pkg::tag_t                      tag;
    } cmd_t;

    logic [lcrs_pkg::LREG_W-1:0] row_length_reg;
    logic [lcrs_pkg::LREG_W-1:0] row_count_reg;
    logic [lcrs_pkg::COEF_W-1:0] along_coeff_reg;
    logic [lcrs_pkg::COEF_W-1:0] across_coeff_reg;

    logic [COL_W-1:0] column_pos_reg;
    logic [COL_W-1:0] column_pos_next;
    logic [ROW_W-1:0] row_pos_reg;
    logic [ROW_W-1:0] row_pos_next;
    logic [COL_W-1:0] drain_pos_reg;
    logic [COL_W-1:0] drain_pos_next;
    logic signed [lcrs_pkg::SAMPLE_W-1:0] held_left_reg;
    logic signed [lcrs_pkg::SAMPLE_W-1:0] drain_left_reg;

    logic             b_valid_reg;
    cmd_t             cmd_reg;
    cmd_t             cmd_next;
    logic [COL_W-1:0] addr_reg;
    logic [COL_W-1:0] addr_next;
    logic [COL_W-1:0] nb_addr;

    logic [LEN_W-1:0] len;
    logic [ROW_W-1:0] rows;
    logic             accept;
    logic             is_drain;

    logic             p_wrap;
    logic [COL_W-1:0] p_col;
    logic [ROW_W-1:0] p_row;
    logic             p_in;
    logic [LEN_W-1:0] p_inc;
    logic             p_last_col;
    logic             d_ready;
    logic             d_over;
    logic [LEN_W-1:0] d_inc;
    logic             d_last;

    logic signed [lcrs_pkg::SAMPLE_W-1:0] up_data;
    logic signed [lcrs_pkg::SAMPLE_W-1:0] mid_data;
    logic signed [lcrs_pkg::SAMPLE_W-1:0] nb_data;

    lcrs_pkg::operands_t           ops;
    logic                          res_valid;
    lcrs_pkg::result_t             res;
    logic [1:0]                    inflight;
    logic [lcrs_pkg::QCNT_W-1:0]   q_count;
    logic                          credit_ok;

    // lengths of zero act as one, lengths above the store size as its size
    always_comb
    begin
        if (row_length_reg == '0)
        begin
            len = LEN_W'(1);
        end
        else if (row_length_reg > lcrs_pkg::LREG_W'(MAX_COLS))
        begin
            len = LEN_W'(MAX_COLS);
        end
        else
        begin
            len = LEN_W'(row_length_reg);
        end

        if (row_count_reg == '0)
        begin
            rows = ROW_W'(1);
        end
        else if (row_count_reg > lcrs_pkg::LREG_W'(MAX_ROWS))
        begin
            rows = ROW_W'(MAX_ROWS);
        end
        else
        begin
            rows = ROW_W'(row_count_reg);
        end
    end

    assign credit_ok = ({1'b0, q_count} + 4'(inflight)) < 4'(lcrs_pkg::QDEPTH);
    assign s_tready  = !b_valid_reg && credit_ok;
    assign accept    = s_tvalid && s_tready;
    assign is_drain  = (s_tuser == lcrs_pkg::ACTION_DRAIN);

    // position bookkeeping for the request on the slave side
    always_comb
    begin
        p_wrap     = LEN_W'(column_pos_reg) >= len;
        p_col      = p_wrap ? '0 : column_pos_reg;
        p_row      = p_wrap ? ROW_W'(row_pos_reg + 1'b1) : row_pos_reg;
        p_in       = p_row < rows;
        p_inc      = LEN_W'(p_col) + 1'b1;
        p_last_col = p_inc >= len;

        d_ready    = row_pos_reg >= rows;
        d_over     = LEN_W'(drain_pos_reg) >= len;
        d_inc      = LEN_W'(drain_pos_reg) + 1'b1;
        d_last     = d_inc >= len;
    end

    always_comb
    begin
        column_pos_next = column_pos_reg;
        row_pos_next    = row_pos_reg;
        drain_pos_next  = drain_pos_reg;
        cmd_next        = '0;
        cmd_next.sample = signed'(s_tdata);
        addr_next       = p_col;

        if (!is_drain)
        begin
            cmd_next.write      = p_in;
            cmd_next.upd_left   = p_in;
            cmd_next.emit       = p_in && (p_row != '0);
            cmd_next.up_zero    = p_row < ROW_W'(2);
            cmd_next.left_zero  = (p_col == '0);
            cmd_next.right_zero = p_last_col;
            cmd_next.down_zero  = 1'b0;
            cmd_next.tag.row    = lcrs_pkg::IDX_W'(p_row - 1'b1);
            cmd_next.tag.col    = lcrs_pkg::IDX_W'(p_col);
            cmd_next.tag.last   = 1'b0;
            if (p_in)
            begin
                if (p_last_col)
                begin
                    column_pos_next = '0;
                    row_pos_next    = ROW_W'(p_row + 1'b1);
                end
                else
                begin
                    column_pos_next = COL_W'(p_inc);
                    row_pos_next    = p_row;
                end
            end
            else
            begin
                column_pos_next = p_col;
                row_pos_next    = p_row;
            end
        end
        else
        begin
            addr_next           = drain_pos_reg;
            cmd_next.emit       = d_ready && !d_over;
            cmd_next.up_zero    = rows < ROW_W'(2);
            cmd_next.left_zero  = (drain_pos_reg == '0);
            cmd_next.right_zero = d_last;
            cmd_next.down_zero  = 1'b1;
            cmd_next.tag.row    = lcrs_pkg::IDX_W'(rows - 1'b1);
            cmd_next.tag.col    = lcrs_pkg::IDX_W'(drain_pos_reg);
            cmd_next.tag.last   = d_last;
            if (d_ready)
            begin
                if (d_over || d_last)
                begin
                    column_pos_next = '0;
                    row_pos_next    = '0;
                    drain_pos_next  = '0;
                end
                else
                begin
                    drain_pos_next = COL_W'(d_inc);
                end
            end
        end
    end

    // right neighbour of the last store column is never used
    assign nb_addr = (addr_next == COL_W'(MAX_COLS - 1)) ? '0 : COL_W'(addr_next + 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg   <= lcrs_pkg::ROW_LENGTH_RST;
            row_count_reg    <= lcrs_pkg::ROW_COUNT_RST;
            along_coeff_reg  <= lcrs_pkg::COEFF_RST;
            across_coeff_reg <= lcrs_pkg::COEFF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                lcrs_pkg::REG_ROW_LENGTH:   row_length_reg   <= cfg_wdata[lcrs_pkg::LREG_W-1:0];
                lcrs_pkg::REG_ROW_COUNT:    row_count_reg    <= cfg_wdata[lcrs_pkg::LREG_W-1:0];
                lcrs_pkg::REG_ALONG_COEFF:  along_coeff_reg  <= cfg_wdata;
                lcrs_pkg::REG_ACROSS_COEFF: across_coeff_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_pos_reg <= '0;
            row_pos_reg    <= '0;
            drain_pos_reg  <= '0;
            held_left_reg  <= '0;
            drain_left_reg <= '0;
            b_valid_reg    <= 1'b0;
        end
        else
        begin
            b_valid_reg <= accept;
            if (accept)
            begin
                column_pos_reg <= column_pos_next;
                row_pos_reg    <= row_pos_next;
                drain_pos_reg  <= drain_pos_next;
            end
            // hold this column's middle value as the next one's left neighbour
            if (b_valid_reg && cmd_reg.upd_left)
            begin
                held_left_reg <= mid_data;
            end
            // track the current middle value left of the drain position
            if (b_valid_reg && cmd_reg.down_zero && cmd_reg.emit)
            begin
                drain_left_reg <= mid_data;
            end
            else if (b_valid_reg && cmd_reg.write && (drain_pos_reg != '0)
                     && (addr_reg == COL_W'(drain_pos_reg - 1'b1)))
            begin
                drain_left_reg <= cmd_reg.sample;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd_next;
            addr_reg <= addr_next;
        end
    end

    lcrs_line_store #(
        .DEPTH (MAX_COLS),
        .AW    (COL_W)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr   (addr_next),
        .nb_addr   (nb_addr),
        .wr_en     (b_valid_reg && cmd_reg.write),
        .wr_addr   (addr_reg),
        .wr_upper  (mid_data),
        .wr_middle (cmd_reg.sample),
        .up_data   (up_data),
        .mid_data  (mid_data),
        .nb_data   (nb_data)
    );

    always_comb
    begin
        ops.up    = cmd_reg.up_zero    ? '0 : up_data;
        ops.mid   = mid_data;
        ops.left  = cmd_reg.left_zero  ? '0 :
                    (cmd_reg.down_zero ? drain_left_reg : held_left_reg);
        ops.right = cmd_reg.right_zero ? '0 : nb_data;
        ops.down  = cmd_reg.down_zero  ? '0 : cmd_reg.sample;
        ops.tag   = cmd_reg.tag;
    end

    lcrs_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (b_valid_reg && cmd_reg.emit),
        .ops          (ops),
        .along_coeff  (along_coeff_reg),
        .across_coeff (across_coeff_reg),
        .res_valid    (res_valid),
        .res          (res),
        .inflight     (inflight)
    );

    lcrs_out_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_valid),
        .push_res (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .count    (q_count)
    );

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, q_count} + 4'(inflight)) <= 4'(lcrs_pkg::QDEPTH))
        else $error("results in flight exceed queue space");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_drain && d_ready && !d_over && d_last)
        |=> (row_pos_reg == '0) && (drain_pos_reg == '0) && (column_pos_reg == '0))
        else $error("frame did not restart after its last drain");

    a_last_column: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast)
        |-> (m_tdata[lcrs_pkg::COL_LSB +: lcrs_pkg::IDX_W] == lcrs_pkg::IDX_W'(len - 1'b1)))
        else $error("frame end flagged away from the last column");

endmodule
`default_nettype wire
